@@ sv/csv_line_field_splitter_core_macros.svh @@
// ----------------------------------------------------------------------------
// csv line field splitter assertion macros
// shared property wrappers, clocked on aclk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef CSV_LINE_FIELD_SPLITTER_CORE_MACROS_SVH
`define CSV_LINE_FIELD_SPLITTER_CORE_MACROS_SVH

// same-cycle implication
`define CSVS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CSVS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/csvs_pkg.sv @@
// ----------------------------------------------------------------------------
// csvs_pkg
// types, limits and character codes of the csv line field splitter
// ----------------------------------------------------------------------------
package csvs_pkg;

    localparam int MAX_FIELDS     = 64;
    localparam int MAX_LINE_BYTES = 65535;

    // fields_seen runs 1..MAX_FIELDS, line offset runs 0..MAX_LINE_BYTES
    localparam int FS_W   = $clog2(MAX_FIELDS + 1);
    localparam int LINE_W = $clog2(MAX_LINE_BYTES + 1);

    localparam int M_TDATA_W = 48;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_QUOTE     = 8'd34;

    localparam logic [7:0] DELIM_RESET       = 8'd44;
    localparam logic [6:0] FIELD_COUNT_RESET = 7'd1;

    typedef enum logic [0:0] {
        REG_DELIMITER   = 1'b0,
        REG_FIELD_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_MANY   = 3'd1,
        ST_OPEN_QUOTE = 3'd2,
        ST_BAD_COUNT  = 3'd3,
        ST_TOO_LONG   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic        boundary;
        logic [5:0]  field_number;
        logic [15:0] field_start;
        logic        line_done;
        status_t     status;
        logic [15:0] line_length;
    } result_t;

endpackage

@@ sv/csvs_in_stage.sv @@
// ----------------------------------------------------------------------------
// csvs_in_stage
// input register; holds one byte word until the parser takes it
// ----------------------------------------------------------------------------
module csvs_in_stage
    import csvs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // text_byte
    input  logic       s_tlast,   // buffer_end
    input  logic       take,
    output logic       in_valid,
    output in_item_t   in_item
);

    logic     in_valid_reg;
    logic     in_valid_next;
    in_item_t in_item_reg;

    // free when empty or when the held word leaves this cycle
    assign s_tready = !in_valid_reg || take;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (take) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.text_byte  <= s_tdata;
            in_item_reg.buffer_end <= s_tlast;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_item  = in_item_reg;

endmodule

@@ sv/csvs_parser.sv @@
// ----------------------------------------------------------------------------
// csvs_parser
// line state, config registers and the per-byte split decision
// ----------------------------------------------------------------------------
module csvs_parser
    import csvs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       take,
    input  in_item_t   in_item,
    output logic       res_emit,
    output result_t    res
);

    logic [7:0]        delimiter_reg;
    logic [6:0]        field_count_reg;
    logic              in_quote_reg,    in_quote_next;
    logic              after_escape_reg, after_escape_next;
    logic [FS_W-1:0]   fields_seen_reg, fields_seen_next;
    logic [LINE_W-1:0] line_offset_reg, line_offset_next;
    logic              draining_reg,    draining_next;

    logic [FS_W-1:0]   wanted;
    logic [LINE_W-1:0] length;
    logic              is_nl;
    logic              ends;
    logic              q2;
    logic              e2;
    logic [FS_W-1:0]   fs2;
    logic              split;
    logic              too_many;
    logic              emit;
    result_t           r;

    // clamp field_count into 1..MAX_FIELDS
    always_comb begin
        if (field_count_reg == '0) begin
            wanted = FS_W'(1);
        end else if (int'(field_count_reg) > MAX_FIELDS) begin
            wanted = FS_W'(MAX_FIELDS);
        end else begin
            wanted = FS_W'(field_count_reg);
        end
    end

    assign is_nl  = (in_item.text_byte == CH_NEWLINE);
    assign ends   = is_nl || in_item.buffer_end;
    assign length = line_offset_reg + LINE_W'(1);

    // quote, escape and delimiter tracking for a byte that is not a newline
    always_comb begin
        q2       = in_quote_reg;
        e2       = 1'b0;
        fs2      = fields_seen_reg;
        split    = 1'b0;
        too_many = 1'b0;
        if (after_escape_reg) begin
            e2 = 1'b0;
        end else if (in_quote_reg) begin
            e2 = (in_item.text_byte == CH_BACKSLASH);
            q2 = (in_item.text_byte != CH_QUOTE);
        end else begin
            e2 = (in_item.text_byte == CH_BACKSLASH);
            q2 = (in_item.text_byte == CH_QUOTE);
            if (in_item.text_byte == delimiter_reg) begin
                if (fields_seen_reg >= wanted) begin
                    too_many = 1'b1;
                end else begin
                    split = 1'b1;
                    fs2   = fields_seen_reg + FS_W'(1);
                end
            end
        end
    end

    always_comb begin
        in_quote_next     = in_quote_reg;
        after_escape_next = after_escape_reg;
        fields_seen_next  = fields_seen_reg;
        line_offset_next  = line_offset_reg;
        draining_next     = draining_reg;
        emit              = 1'b0;
        r                 = '0;
        r.status          = ST_OK;

        if (draining_reg) begin
            if (ends) begin
                draining_next = 1'b0;
                in_quote_next = 1'b0;
                after_escape_next = 1'b0;
                fields_seen_next  = FS_W'(1);
                line_offset_next  = '0;
            end
        end else if (line_offset_reg >= LINE_W'(MAX_LINE_BYTES)) begin
            emit          = 1'b1;
            r.line_done   = 1'b1;
            r.status      = ST_TOO_LONG;
            r.line_length = 16'(MAX_LINE_BYTES);
            if (ends) begin
                in_quote_next     = 1'b0;
                after_escape_next = 1'b0;
                fields_seen_next  = FS_W'(1);
                line_offset_next  = '0;
            end else begin
                draining_next = 1'b1;
            end
        end else if (is_nl) begin
            emit          = 1'b1;
            r.line_done   = 1'b1;
            r.line_length = 16'(length);
            if (in_quote_reg || after_escape_reg) begin
                r.status = ST_OPEN_QUOTE;
            end else if (fields_seen_reg != wanted) begin
                r.status = ST_BAD_COUNT;
            end
            in_quote_next     = 1'b0;
            after_escape_next = 1'b0;
            fields_seen_next  = FS_W'(1);
            line_offset_next  = '0;
        end else if (too_many) begin
            emit          = 1'b1;
            r.line_done   = 1'b1;
            r.status      = ST_TOO_MANY;
            r.line_length = 16'(length);
            if (in_item.buffer_end) begin
                in_quote_next     = 1'b0;
                after_escape_next = 1'b0;
                fields_seen_next  = FS_W'(1);
                line_offset_next  = '0;
            end else begin
                draining_next = 1'b1;
            end
        end else if (in_item.buffer_end) begin
            // last byte of the buffer closes the line with the updated state
            emit          = 1'b1;
            r.line_done   = 1'b1;
            r.line_length = 16'(length);
            if (q2 || e2) begin
                r.status = ST_OPEN_QUOTE;
            end else if (fs2 != wanted) begin
                r.status = ST_BAD_COUNT;
            end
            in_quote_next     = 1'b0;
            after_escape_next = 1'b0;
            fields_seen_next  = FS_W'(1);
            line_offset_next  = '0;
        end else begin
            in_quote_next     = q2;
            after_escape_next = e2;
            fields_seen_next  = fs2;
            line_offset_next  = length;
            if (split) begin
                emit           = 1'b1;
                r.boundary     = 1'b1;
                r.field_number = 6'(fields_seen_reg);
                r.field_start  = 16'(length);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg   <= DELIM_RESET;
            field_count_reg <= FIELD_COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DELIMITER:   delimiter_reg   <= cfg_wdata;
                REG_FIELD_COUNT: field_count_reg <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quote_reg     <= 1'b0;
            after_escape_reg <= 1'b0;
            fields_seen_reg  <= FS_W'(1);
            line_offset_reg  <= '0;
            draining_reg     <= 1'b0;
        end else if (take) begin
            in_quote_reg     <= in_quote_next;
            after_escape_reg <= after_escape_next;
            fields_seen_reg  <= fields_seen_next;
            line_offset_reg  <= line_offset_next;
            draining_reg     <= draining_next;
        end
    end

    assign res_emit = take && emit;
    assign res      = r;

endmodule

@@ sv/csv_line_field_splitter_core.sv @@
// ----------------------------------------------------------------------------
// csv_line_field_splitter_core
// splits text lines into fields at a delimiter, honoring quotes and escapes
//
//   channel  dir  carries
//   s_       in   one text byte per word, tlast on the buffer's last byte
//   m_       out  field start (tuser high) or line status (tlast high)
//   cfg_     in   delimiter and field count writes
//
// one byte per clock sustained while m_tready stays high; a byte's result word
// is registered after acceptance (input register, then result register)
// the whole parse step is one pass of logic between those two registers
// aresetn is synchronous; it clears line state and restores delimiter ','
// and field count 1
// s_tready drops only while the input register is full and the result word
// is held by a low m_tready
// ----------------------------------------------------------------------------
`include "csv_line_field_splitter_core_macros.svh"

module csv_line_field_splitter_core
    import csvs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // text_byte
    input  logic                 s_tlast,   // buffer_end
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // field_number, field_start, status, line_length
    output logic                 m_tlast,   // line_done
    output logic                 m_tuser,   // boundary
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [7:0]           cfg_wdata
);

    logic     in_valid;
    in_item_t in_item;
    logic     take;
    logic     out_free;
    logic     res_emit;
    result_t  res;

    logic     out_valid_reg;
    logic     out_valid_next;
    result_t  out_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign take     = in_valid && out_free;

    csvs_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    csvs_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .in_item   (in_item),
        .res_emit  (res_emit),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = res_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_emit) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.boundary;
    assign m_tlast  = out_reg.line_done;
    assign m_tdata  = {7'b0, out_reg.line_length, out_reg.status,
                       out_reg.field_start, out_reg.field_number};

    `CSVS_ASSERT_NEXT(a_in_hold, in_valid && !take, in_valid && $stable(in_item), "input word lost while stalled")
    `CSVS_ASSERT_NEXT(a_res_lands, take && res_emit, m_tvalid && (out_reg == $past(res)), "parser result not registered")
    `CSVS_ASSERT(a_split_word, m_tvalid && m_tuser, !m_tlast && (out_reg.field_start != '0), "bad field start word")
    `CSVS_ASSERT(a_long_length, m_tvalid && m_tlast && (out_reg.status == ST_TOO_LONG), out_reg.line_length == 16'(MAX_LINE_BYTES), "too-long line with wrong length")

endmodule

@@ dv/csv_line_field_splitter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv line field splitter checker
// follows register writes and accepted text bytes, works out the field starts
// and line results they cause, and compares every result word against them
// ----------------------------------------------------------------------------
module csv_line_field_splitter_checker
    import csvs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [7:0]           cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    logic [7:0]  delim_q;
    logic [6:0]  count_q;
    logic        quoted;
    logic        escaped;
    int unsigned fields;
    int unsigned offset;
    logic        dropping;

    result_t     expected_results[$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void start_line();
        quoted   = 1'b0;
        escaped  = 1'b0;
        fields   = 1;
        offset   = 0;
        dropping = 1'b0;
    endfunction

    function automatic result_t line_result(status_t st, int unsigned len);
        result_t r;
        r             = '0;
        r.line_done   = 1'b1;
        r.status      = st;
        r.line_length = 16'(len);
        return r;
    endfunction

    function automatic status_t end_status(int unsigned want);
        if (quoted || escaped) return ST_OPEN_QUOTE;
        if (fields != want) return ST_BAD_COUNT;
        return ST_OK;
    endfunction

    // returns 1 when the byte produces a result word
    function automatic bit predict_word(input logic [7:0] b, input logic last,
                                        output result_t r);
        logic        ends;
        logic        split;
        int unsigned want;
        int unsigned len;
        r     = '0;
        split = 1'b0;
        ends  = (b == CH_NEWLINE) || last;
        if (count_q == 0) want = 1;
        else if (count_q > MAX_FIELDS) want = MAX_FIELDS;
        else want = count_q;

        if (dropping) begin
            if (ends) start_line();
            return 1'b0;
        end
        if (offset >= MAX_LINE_BYTES) begin
            if (ends) start_line();
            else dropping = 1'b1;
            r = line_result(ST_TOO_LONG, MAX_LINE_BYTES);
            return 1'b1;
        end

        len = offset + 1;
        if (b == CH_NEWLINE) begin
            r = line_result(end_status(want), len);
            start_line();
            return 1'b1;
        end

        if (escaped) begin
            escaped = 1'b0;
        end else if (quoted) begin
            escaped = (b == CH_BACKSLASH);
            quoted  = (b != CH_QUOTE);
        end else begin
            escaped = (b == CH_BACKSLASH);
            quoted  = (b == CH_QUOTE);
            if (b == delim_q) begin
                if (fields >= want) begin
                    if (last) start_line();
                    else dropping = 1'b1;
                    r = line_result(ST_TOO_MANY, len);
                    return 1'b1;
                end
                split  = 1'b1;
                fields = fields + 1;
            end
        end

        // a delimiter on the buffer's last byte only gives the line result
        if (last) begin
            r = line_result(end_status(want), len);
            start_line();
            return 1'b1;
        end

        offset = len;
        if (split) begin
            r.boundary     = 1'b1;
            r.field_number = 6'(fields - 1);
            r.field_start  = 16'(len);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t exp_word;
        result_t got_word;
        if (!aresetn) begin
            delim_q = DELIM_RESET;
            count_q = FIELD_COUNT_RESET;
            start_line();
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_DELIMITER) delim_q = cfg_wdata;
                else if (cfg_index == REG_FIELD_COUNT) count_q = cfg_wdata[6:0];
            end

            if (m_tvalid && m_tready) begin
                got_word.boundary     = m_tuser;
                got_word.field_number = m_tdata[5:0];
                got_word.field_start  = m_tdata[21:6];
                got_word.status       = status_t'(m_tdata[24:22]);
                got_word.line_length  = m_tdata[40:25];
                got_word.line_done    = m_tlast;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: tuser %0b tlast %0b tdata %h",
                           m_tuser, m_tlast, m_tdata);
                    fail_count++;
                end else begin
                    exp_word = expected_results.pop_front();
                    check_field("boundary", exp_word.boundary, got_word.boundary);
                    check_field("field_number", exp_word.field_number,
                                got_word.field_number);
                    check_field("field_start", exp_word.field_start,
                                got_word.field_start);
                    check_field("line_done", exp_word.line_done, got_word.line_done);
                    check_field("status", exp_word.status, got_word.status);
                    check_field("line_length", exp_word.line_length,
                                got_word.line_length);
                end
            end

            if (s_tvalid && s_tready) begin
                if (predict_word(s_tdata, s_tlast, exp_word))
                    expected_results.push_back(exp_word);
            end
        end
        pending = expected_results.size();
    end

endmodule

@@ dv/tb_csv_line_field_splitter_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv line field splitter testbench
// directed lines for quotes, escapes and count errors, then random lines
// and noise under several delimiter and field count settings, with random
// source gaps and sink stalls; the checker does the comparing
// ----------------------------------------------------------------------------
module tb_csv_line_field_splitter_core;
    import csvs_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_WORDS  = 200;
    localparam int SETTLE_TICKS = 8;

    localparam logic [7:0] DELIM_SET [6] = '{8'd44, 8'd0, 8'd255, 8'd9, CH_QUOTE,
                                             CH_BACKSLASH};
    // 0 and 127 exercise the clamp, 130 the masking of bit 7
    localparam logic [7:0] COUNT_SET [6] = '{8'd3, 8'd1, 8'd127, 8'd0, 8'd5, 8'd130};
    localparam int SRC_IDLE [4] = '{0, 47, 0, 29};
    localparam int SNK_IDLE [4] = '{0, 0, 47, 29};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [0:0]           cfg_index = '0;
    logic [7:0]           cfg_wdata = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int words_sent  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    logic [7:0]  cur_delim     = DELIM_RESET;
    int unsigned fields_wanted = 1;

    csv_line_field_splitter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    csv_line_field_splitter_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #6 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("csv_line_field_splitter_core verification failed");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input logic last_on_final);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], last_on_final && (i == txt.len() - 1));
    endtask

    // wait out every pending result plus any dropped bytes still in flight
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == REG_DELIMITER) begin
            cur_delim = v;
        end else begin
            fields_wanted = v[6:0];
            if (fields_wanted == 0) fields_wanted = 1;
            if (fields_wanted > MAX_FIELDS) fields_wanted = MAX_FIELDS;
        end
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h20, 8'h7e));
        if (c == CH_QUOTE || c == CH_BACKSLASH || c == cur_delim) c = 8'h5f;
        return c;
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 7))
            0:       return CH_NEWLINE;
            1:       return cur_delim;
            2:       return CH_QUOTE;
            3:       return CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) send_byte(special_char(), $urandom_range(0, 15) == 0);
    endtask

    // mostly well-formed line with quoted, escaped and plain fields
    task automatic send_record();
        logic [7:0] line_q[$];
        int         nf;
        int         len;
        logic       last_flag;
        nf = fields_wanted;
        case ($urandom_range(0, 9))
            0:       if (nf > 1) nf = nf - 1;
            1:       nf = nf + 1;
            default: ;
        endcase
        for (int f = 0; f < nf; f++) begin
            if (f > 0) line_q.push_back(cur_delim);
            len = $urandom_range(0, 5);
            case ($urandom_range(0, 9))
                6, 7: begin
                    line_q.push_back(CH_QUOTE);
                    repeat (len) begin
                        case ($urandom_range(0, 3))
                            0: line_q.push_back(cur_delim);
                            1: begin
                                line_q.push_back(CH_BACKSLASH);
                                line_q.push_back(special_char());
                            end
                            2: begin
                                line_q.push_back(CH_QUOTE);
                                line_q.push_back(CH_QUOTE);
                            end
                            default: line_q.push_back(plain_char());
                        endcase
                    end
                    line_q.push_back(CH_QUOTE);
                end
                8: begin
                    line_q.push_back(CH_BACKSLASH);
                    case ($urandom_range(0, 2))
                        0:       line_q.push_back(cur_delim);
                        1:       line_q.push_back(CH_QUOTE);
                        default: line_q.push_back(plain_char());
                    endcase
                end
                9: line_q.push_back(8'($urandom_range(0, 255)));
                default: repeat (len) line_q.push_back(plain_char());
            endcase
        end
        case ($urandom_range(0, 5))
            4: begin
                line_q.push_back(plain_char());
                last_flag = 1'b1;
            end
            5: begin
                line_q.push_back(cur_delim);
                last_flag = 1'b1;
            end
            default: begin
                line_q.push_back(CH_NEWLINE);
                last_flag = ($urandom_range(0, 7) == 0);
            end
        endcase
        foreach (line_q[i])
            send_byte(line_q[i], last_flag && (i == line_q.size() - 1));
    endtask

    initial begin
        int start_words;
        int lines;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: ',' and one field, so the comma is one field too many
        send_text("a,b\n", 1'b0);
        wait_drained();
        write_reg(REG_FIELD_COUNT, 8'd2);
        send_text("x,y\n", 1'b0);
        send_text("\"\n", 1'b0);           // newline inside quotes
        send_text("\\\n", 1'b0);           // newline right after an escape
        send_text(",", 1'b1);              // delimiter on the buffer's last byte
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(CH_NEWLINE, 1'b1);
        send_text(",,,q\n", 1'b0);         // too many, rest of line dropped
        send_text(",,", 1'b1);             // too many on the last byte, no drop
        send_text("z\n", 1'b0);

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            write_reg(REG_DELIMITER, DELIM_SET[p]);
            write_reg(REG_FIELD_COUNT, COUNT_SET[p]);
            idle_pct    = SRC_IDLE[p % 4];
            stall_pct   = SNK_IDLE[p % 4];
            start_words = words_sent;
            lines       = 0;
            while (words_sent - start_words < PHASE_WORDS) begin
                if ($urandom_range(0, 4) == 0) send_noise();
                else send_record();
                lines++;
                if (lines % 40 == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("csv_line_field_splitter_core verification clean");
        end else begin
            $display("csv_line_field_splitter_core verification failed");
        end
        $finish;
    end

endmodule
